// ===== rtl/bsml_pkg.sv =====
// Package for the binned sector mask lookup: default parameters, operation and
// status codes, controller states and the structs between controller and lanes.
// No dependencies.
`default_nettype none

package bsml_pkg;

	localparam int NAXES           = 5;
	localparam int DEF_MAX_BINS    = 64;
	localparam int DEF_NUM_SECTORS = 4096;
	localparam int DEF_FRAC_BITS   = 8;
	localparam int CFG_W           = 7;
	localparam int COORD_W         = 16;
	localparam int BOUND_W         = 8;

	localparam logic [CFG_W-1:0] BINS_RESET = 7'd64;
	localparam logic [2:0]       AXIS_LAST  = 3'd4;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_BOUND  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_INS_RD,
		S_INS_WR,
		S_SCHK,
		S_SERR,
		S_SRCH,
		S_BQ_SCAN,
		S_BQ_OUT
	} state_t;

	// Commands from the controller to every lane.
	typedef struct packed {
		logic clr;
		logic rd;
		logic wr;
		logic scan;
		logic srch;
	} lane_cmd_t;

	// What a lane reports back.
	typedef struct packed {
		logic               oor;
		logic               done;
		logic               any;
		logic [BOUND_W-1:0] lo;
		logic [BOUND_W-1:0] hi;
	} lane_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bsml_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bsml_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bsml_lane.sv =====
// One axis lane: bin selection, the axis mask table, per-bin occupancy flags
// and the bin scanner for the boundary query. Depends on bsml_pkg and bsml_ram.
`default_nettype none

module bsml_lane #(
	parameter int MAX_BINS    = bsml_pkg::DEF_MAX_BINS,
	parameter int NUM_SECTORS = bsml_pkg::DEF_NUM_SECTORS,
	parameter int FRAC_BITS   = bsml_pkg::DEF_FRAC_BITS,
	parameter bit IS_PHI      = 1'b0,
	localparam int WORDS      = (NUM_SECTORS + 63) / 64,
	localparam int WW         = (WORDS > 1) ? $clog2(WORDS) : 1,
	localparam int BW         = $clog2(MAX_BINS),
	localparam int AW         = BW + WW
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire bsml_pkg::lane_cmd_t              cmd,
	input  wire logic [bsml_pkg::CFG_W-1:0]       cfg_bins,
	input  wire logic signed [bsml_pkg::COORD_W-1:0] coord,
	input  wire logic [WW-1:0]                    word,
	input  wire logic [AW-1:0]                    clr_addr,
	input  wire logic [5:0]                       bitpos,
	output logic      [63:0]                      rdata,
	output bsml_pkg::lane_stat_t                  stat
);

	localparam int NBW   = $clog2(MAX_BINS + 1);
	localparam int JW    = NBW + 1;
	localparam int DEPTH = MAX_BINS * (2 ** WW);

	logic [NBW-1:0]     n;
	logic [BW-1:0]      nm1;
	logic signed [31:0] cx, raw, lim;
	logic [BW-1:0]      bin;
	logic               oor;

	logic                we;
	logic [AW-1:0]       waddr;
	logic [63:0]         wdata;

	logic [MAX_BINS-1:0] busy_q;

	logic          run_q, done_q, found_q, sv_q;
	logic [JW-1:0] j_q, start_q, bstart_q, bsize_q;
	logic [BW-1:0] lo_q, hi_q;

	logic [BW-1:0] k, km1, kp1;
	logic          b0, good, take, fin;
	logic [JW-1:0] st, size, nsize, jlim;
	logic [JW:0]   hi_sum;

	always_comb begin
		if (cfg_bins == '0) begin
			n = NBW'(1);
		end else if (32'(cfg_bins) > 32'(MAX_BINS)) begin
			n = NBW'(MAX_BINS);
		end else begin
			n = NBW'(cfg_bins);
		end
	end

	assign nm1 = BW'(n - 1'b1);
	assign cx  = 32'(coord);
	assign raw = cx >>> FRAC_BITS;
	assign lim = $signed(32'(n) << FRAC_BITS);
	assign oor = coord[bsml_pkg::COORD_W-1] || (cx > lim);

	// Insert clamps the floored value; a search value sits in 0..n, and only
	// phi folds the top edge back onto bin 0.
	always_comb begin
		if (raw < 0) begin
			bin = '0;
		end else if (raw >= $signed(32'(n))) begin
			bin = (IS_PHI && cmd.srch) ? '0 : nm1;
		end else begin
			bin = BW'(raw);
		end
	end

	assign we    = cmd.clr | cmd.wr;
	assign waddr = cmd.clr ? clr_addr : {bin, word};
	assign wdata = cmd.clr ? '0 : (rdata | (64'(1) << bitpos));

	bsml_ram #(
		.WIDTH(64),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd),
		.raddr({bin, word}),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (cmd.wr) begin
			busy_q[bin] <= 1'b1;
		end
	end

	// Scanner: one bin per cycle; phi walks the ring twice to catch a run
	// that crosses the end.
	assign jlim = IS_PHI ? (JW'(n) << 1) : JW'(n);
	assign k    = (j_q < JW'(n)) ? BW'(j_q) : BW'(j_q - JW'(n));
	assign km1  = (k == '0) ? nm1 : BW'(k - 1'b1);
	assign kp1  = (k == nm1) ? '0 : BW'(k + 1'b1);
	assign b0   = busy_q[k];
	assign good = b0 | busy_q[km1] | busy_q[kp1];
	assign st   = sv_q ? start_q : j_q;
	assign size = JW'(j_q + 1'b1 - st);
	assign take = good && (size > bsize_q) && (bsize_q != JW'(n));
	assign nsize = take ? size : bsize_q;
	assign fin  = (j_q == JW'(jlim - 1'b1)) || (IS_PHI && (nsize == JW'(n)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			sv_q     <= 1'b0;
			j_q      <= '0;
			start_q  <= '0;
			bstart_q <= '0;
			bsize_q  <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
		end else if (cmd.scan) begin
			run_q    <= 1'b1;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			sv_q     <= 1'b0;
			j_q      <= '0;
			bstart_q <= '0;
			bsize_q  <= '0;
		end else if (run_q) begin
			if (b0) begin
				found_q <= 1'b1;
				if (!found_q) begin
					lo_q <= k;
				end
				hi_q <= k;
			end
			if (good) begin
				start_q <= st;
				sv_q    <= 1'b1;
			end else begin
				sv_q <= 1'b0;
			end
			if (take) begin
				bstart_q <= st;
				bsize_q  <= size;
			end
			if (fin) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end else begin
				j_q <= JW'(j_q + 1'b1);
			end
		end
	end

	assign hi_sum = {1'b0, bstart_q} + {1'b0, bsize_q} - 1'b1;

	always_comb begin
		stat.oor  = oor;
		stat.done = done_q;
		stat.any  = found_q;
		if (IS_PHI) begin
			if (bsize_q == '0) begin
				stat.lo = 8'hFF;
				stat.hi = 8'hFE;
			end else begin
				stat.lo = 8'(bstart_q);
				stat.hi = 8'(hi_sum);
			end
		end else begin
			stat.lo = found_q ? 8'(lo_q) : 8'(nm1);
			stat.hi = found_q ? 8'(hi_q) : 8'd0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/binned_sector_mask_lookup_top.sv =====
// Top level of the binned sector mask lookup: controller, configuration
// registers, five axis lanes and the merging output stage.
// Depends on bsml_pkg, bsml_lane and bsml_ram.
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    op, sector, five coordinates
// output    out        out_valid / out_ready  status, chunk_index, sector_mask,
//                                             axis, lower_bin, upper_bin, last
// config    in         cfg_we                 cfg_idx, cfg_data
//
// After reset the tables are cleared one word per cycle, all MAX_BINS * 2**WW words
// (4096 with the defaults), during which no transaction is taken.
// An insert reads the addressed table word and then writes it back with the sector
// bit set. A search reads one chunk at a time; every chunk is a registered read of
// all five tables. A boundary query waits for the slowest scanner before its five
// per-axis results go out; the phi scanner walks the bin ring twice.
// A stalled output holds the controller; one item is worked on at a time.

module binned_sector_mask_lookup_top #(
	parameter int MAX_BINS    = bsml_pkg::DEF_MAX_BINS,
	parameter int NUM_SECTORS = bsml_pkg::DEF_NUM_SECTORS,
	parameter int FRAC_BITS   = bsml_pkg::DEF_FRAC_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          op,
	input  wire logic [11:0]                         sector,
	input  wire logic signed [bsml_pkg::COORD_W-1:0] phi_coord,
	input  wire logic signed [bsml_pkg::COORD_W-1:0] qoverpt_coord,
	input  wire logic signed [bsml_pkg::COORD_W-1:0] d0_coord,
	input  wire logic signed [bsml_pkg::COORD_W-1:0] z0_coord,
	input  wire logic signed [bsml_pkg::COORD_W-1:0] eta_coord,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [1:0]                               status,
	output logic [5:0]                               chunk_index,
	output logic [63:0]                              sector_mask,
	output logic [2:0]                               axis,
	output logic signed [7:0]                        lower_bin,
	output logic signed [7:0]                        upper_bin,
	output logic                                     last,
	input  wire logic                                cfg_we,
	input  wire logic [2:0]                          cfg_idx,
	input  wire logic [bsml_pkg::CFG_W-1:0]          cfg_data
);

	localparam int WORDS = (NUM_SECTORS + 63) / 64;
	localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW    = $clog2(MAX_BINS);
	localparam int AW    = BW + WW;
	localparam int DEPTH = MAX_BINS * (2 ** WW);

	bsml_pkg::state_t state_q, state_d;

	logic [11:0]                               sector_q;
	logic signed [bsml_pkg::COORD_W-1:0]       coord_q [bsml_pkg::NAXES];
	logic [bsml_pkg::CFG_W-1:0]                bins_q  [bsml_pkg::NAXES];
	logic [AW-1:0]                             clr_q;
	logic [WW-1:0]                             iss_w_q, ret_w_q, word;
	logic                                      iss_all_q, rd_pend_q;
	logic [2:0]                                ax_q;

	bsml_pkg::lane_cmd_t  cmd;
	bsml_pkg::lane_stat_t lstat [bsml_pkg::NAXES];
	logic [63:0]          lrdata [bsml_pkg::NAXES];
	logic [63:0]          merged;
	logic [bsml_pkg::NAXES-1:0] oor_v, done_v;

	logic accept, ofree, issue, load_err, load_mask, load_bq;
	logic ret_last, iss_last;

	logic [1:0]  status_q;
	logic [5:0]  chunk_q;
	logic [63:0] mask_q;
	logic [2:0]  axis_q;
	logic [7:0]  lo_q, hi_q;
	logic        last_q, out_valid_q;

	assign accept   = in_valid && in_ready;
	assign ofree    = !out_valid_q || out_ready;
	assign ret_last = (ret_w_q == WW'(WORDS - 1));
	assign iss_last = (iss_w_q == WW'(WORDS - 1));
	assign word     = (state_q == bsml_pkg::S_SRCH) ? iss_w_q : WW'(sector_q >> 6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bsml_pkg::NAXES; i++) begin
				bins_q[i] <= bsml_pkg::BINS_RESET;
			end
		end else if (cfg_we && (32'(cfg_idx) < bsml_pkg::NAXES)) begin
			bins_q[cfg_idx] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sector_q   <= sector;
			coord_q[0] <= phi_coord;
			coord_q[1] <= qoverpt_coord;
			coord_q[2] <= d0_coord;
			coord_q[3] <= z0_coord;
			coord_q[4] <= eta_coord;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsml_pkg::S_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = bsml_pkg::S_IDLE;
				end
			end
			bsml_pkg::S_IDLE: begin
				if (accept) begin
					case (op)
						bsml_pkg::OP_INSERT: begin
							if (32'(sector) < NUM_SECTORS) begin
								state_d = bsml_pkg::S_INS_RD;
							end
						end
						bsml_pkg::OP_SEARCH: state_d = bsml_pkg::S_SCHK;
						bsml_pkg::OP_BOUND:  state_d = bsml_pkg::S_BQ_SCAN;
						default:             state_d = bsml_pkg::S_IDLE;
					endcase
				end
			end
			bsml_pkg::S_INS_RD: state_d = bsml_pkg::S_INS_WR;
			bsml_pkg::S_INS_WR: state_d = bsml_pkg::S_IDLE;
			bsml_pkg::S_SCHK: begin
				state_d = (|oor_v) ? bsml_pkg::S_SERR : bsml_pkg::S_SRCH;
			end
			bsml_pkg::S_SERR: begin
				if (ofree) begin
					state_d = bsml_pkg::S_IDLE;
				end
			end
			bsml_pkg::S_SRCH: begin
				if (rd_pend_q && ret_last) begin
					state_d = bsml_pkg::S_IDLE;
				end
			end
			bsml_pkg::S_BQ_SCAN: begin
				if (&done_v) begin
					state_d = bsml_pkg::S_BQ_OUT;
				end
			end
			bsml_pkg::S_BQ_OUT: begin
				if (ofree && (ax_q == bsml_pkg::AXIS_LAST)) begin
					state_d = bsml_pkg::S_IDLE;
				end
			end
			default: state_d = bsml_pkg::S_IDLE;
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		issue     = 1'b0;
		load_err  = 1'b0;
		load_mask = 1'b0;
		load_bq   = 1'b0;
		unique case (state_q)
			bsml_pkg::S_CLEAR:  cmd.clr = 1'b1;
			bsml_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.scan = in_valid && (op == bsml_pkg::OP_BOUND);
			end
			bsml_pkg::S_INS_RD: cmd.rd = 1'b1;
			bsml_pkg::S_INS_WR: cmd.wr = 1'b1;
			bsml_pkg::S_SCHK:   cmd.srch = 1'b1;
			bsml_pkg::S_SERR:   load_err = ofree;
			bsml_pkg::S_SRCH: begin
				cmd.srch  = 1'b1;
				issue     = !rd_pend_q && ofree && !iss_all_q;
				cmd.rd    = issue;
				load_mask = rd_pend_q;
			end
			bsml_pkg::S_BQ_SCAN: begin
			end
			bsml_pkg::S_BQ_OUT: load_bq = ofree;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bsml_pkg::S_CLEAR;
			clr_q     <= '0;
			iss_w_q   <= '0;
			ret_w_q   <= '0;
			iss_all_q <= 1'b0;
			rd_pend_q <= 1'b0;
			ax_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bsml_pkg::S_CLEAR) begin
				clr_q <= AW'(clr_q + 1'b1);
			end
			if (state_q == bsml_pkg::S_SCHK) begin
				iss_w_q   <= '0;
				ret_w_q   <= '0;
				iss_all_q <= 1'b0;
				rd_pend_q <= 1'b0;
			end else if (state_q == bsml_pkg::S_SRCH) begin
				rd_pend_q <= issue;
				if (issue) begin
					iss_w_q <= WW'(iss_w_q + 1'b1);
					if (iss_last) begin
						iss_all_q <= 1'b1;
					end
				end
				if (load_mask) begin
					ret_w_q <= WW'(ret_w_q + 1'b1);
				end
			end
			if (state_q == bsml_pkg::S_BQ_SCAN) begin
				ax_q <= '0;
			end else if (load_bq) begin
				ax_q <= 3'(ax_q + 1'b1);
			end
		end
	end

	for (genvar i = 0; i < bsml_pkg::NAXES; i++) begin : g_lane
		bsml_lane #(
			.MAX_BINS   (MAX_BINS),
			.NUM_SECTORS(NUM_SECTORS),
			.FRAC_BITS  (FRAC_BITS),
			.IS_PHI     (i == 0)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.cfg_bins(bins_q[i]),
			.coord   (coord_q[i]),
			.word    (word),
			.clr_addr(clr_q),
			.bitpos  (sector_q[5:0]),
			.rdata   (lrdata[i]),
			.stat    (lstat[i])
		);
		assign oor_v[i]  = lstat[i].oor;
		assign done_v[i] = lstat[i].done;
	end

	// Merge: a sector matches when every axis has it in the selected bin.
	always_comb begin
		merged = '1;
		for (int i = 0; i < bsml_pkg::NAXES; i++) begin
			merged = merged & lrdata[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_err || load_mask || load_bq) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_err) begin
			status_q <= bsml_pkg::ST_RANGE;
			chunk_q  <= '0;
			mask_q   <= '0;
			axis_q   <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			last_q   <= 1'b1;
		end else if (load_mask) begin
			status_q <= bsml_pkg::ST_OK;
			chunk_q  <= 6'(ret_w_q);
			mask_q   <= merged;
			axis_q   <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			last_q   <= ret_last;
		end else if (load_bq) begin
			status_q <= lstat[ax_q].any ? bsml_pkg::ST_OK : bsml_pkg::ST_EMPTY;
			chunk_q  <= '0;
			mask_q   <= '0;
			axis_q   <= ax_q;
			lo_q     <= lstat[ax_q].lo;
			hi_q     <= lstat[ax_q].hi;
			last_q   <= (ax_q == bsml_pkg::AXIS_LAST);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign chunk_index = chunk_q;
	assign sector_mask = mask_q;
	assign axis        = axis_q;
	assign lower_bin   = $signed(lo_q);
	assign upper_bin   = $signed(hi_q);
	assign last        = last_q;

endmodule

`default_nettype wire
